@@ hdl/fmvc_pkg.sv @@
// Shared types, constants and lookup tables for the FM voice format converter.
// Used by the decode, convert and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fmvc_pkg;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Packed voice store
  localparam int unsigned VOICE_DEPTH = 128;
  localparam int unsigned VOICE_AW    = 7;
  localparam logic [VOICE_AW-1:0] ADDR_ALG = 7'd40;
  localparam logic [VOICE_AW-1:0] ADDR_LFO = 7'd45;

  // Converted index layout
  localparam logic [7:0] OP_BYTES       = 8'd21;
  localparam logic [7:0] IDX_OP_END     = 8'd126;
  localparam logic [7:0] IDX_WAVE_FIRST = 8'd155;
  localparam logic [7:0] IDX_WAVE_LAST  = 8'd160;

  // Field values
  localparam logic [7:0] CAP_LEVEL     = 8'd99;
  localparam logic [7:0] CAP_TRANSPOSE = 8'd48;
  localparam logic [7:0] BREAK_DEF     = 8'd39;
  localparam logic [7:0] COARSE_DEF    = 8'd1;
  localparam logic [7:0] NAME_BLANK    = 8'd32;

  // Algorithms with a non-default operator placement
  localparam logic [2:0] ALG_MAP_B = 3'd1;
  localparam logic [2:0] ALG_MAP_C = 3'd2;

  // Envelope rescale: floor(b*99/d) = (b * 99 * ceil(2^S/d)) >> S for b < d
  localparam int unsigned SCALE_SHIFT = 17;
  localparam int unsigned SCALE_PW    = 26;
  localparam logic [20:0] SCALE_K20 = 21'(99 * (((1 << SCALE_SHIFT) + 19) / 20));
  localparam logic [20:0] SCALE_K31 = 21'(99 * (((1 << SCALE_SHIFT) + 30) / 31));
  localparam logic [20:0] SCALE_K10 = 21'(99 * (((1 << SCALE_SHIFT) + 9) / 10));
  localparam logic [20:0] SCALE_K15 = 21'(99 * (((1 << SCALE_SHIFT) + 14) / 15));

  typedef enum logic [3:0] {
    KIND_CONST,
    KIND_SCALE20,
    KIND_SCALE31,
    KIND_SCALE10,
    KIND_SCALE15,
    KIND_CAP99,
    KIND_CAP48,
    KIND_AMS,
    KIND_SENS,
    KIND_LOW3,
    KIND_COARSE,
    KIND_FINE,
    KIND_DETUNE,
    KIND_NAME,
    KIND_WAVE
  } conv_kind_e;

  // Decode stage to convert stage
  typedef struct packed {
    logic       pend;
    conv_kind_e kind;
    logic [7:0] cval;
    logic       present;
  } stage_t;

  typedef struct packed {
    logic       used;
    logic [1:0] slot;
  } op_slot_t;

  localparam logic [6:0] OP_BASE  [4] = '{7'd30, 7'd10, 7'd20, 7'd0};
  localparam logic [6:0] WAVE_SRC [4] = '{7'd80, 7'd76, 7'd78, 7'd74};
  localparam logic [7:0] ALG_CODE [8] = '{8'd0, 8'd13, 8'd7, 8'd6, 8'd4, 8'd21, 8'd30, 8'd31};
  localparam logic [7:0] LFO_WAVE [4] = '{8'd2, 8'd3, 8'd0, 8'd5};

  localparam logic [4:0] RATIO_COARSE [64] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd2,  5'd2,  5'd3,  5'd2,  5'd2,  5'd4,  5'd4,  5'd3,
    5'd5,  5'd3,  5'd5,  5'd6,  5'd4,  5'd4,  5'd7,  5'd7,
    5'd5,  5'd8,  5'd8,  5'd5,  5'd9,  5'd6,  5'd7,  5'd10,
    5'd6,  5'd7,  5'd11, 5'd10, 5'd12, 5'd7,  5'd8,  5'd8,
    5'd13, 5'd8,  5'd14, 5'd10, 5'd9,  5'd15, 5'd14, 5'd9,
    5'd10, 5'd16, 5'd11, 5'd10, 5'd11, 5'd12, 5'd11, 5'd18,
    5'd13, 5'd12, 5'd20, 5'd14, 5'd13, 5'd15, 5'd14, 5'd15
  };

  localparam logic [6:0] RATIO_FINE [64] = '{
    7'd0,  7'd42, 7'd56, 7'd74, 7'd0,  7'd41, 7'd57, 7'd73,
    7'd0,  7'd41, 7'd0,  7'd57, 7'd73, 7'd0,  7'd6,  7'd57,
    7'd0,  7'd73, 7'd13, 7'd0,  7'd57, 7'd73, 7'd0,  7'd1,
    7'd57, 7'd0,  7'd6,  7'd73, 7'd0,  7'd57, 7'd41, 7'd0,
    7'd73, 7'd57, 7'd0,  7'd13, 7'd0,  7'd73, 7'd57, 7'd59,
    7'd0,  7'd73, 7'd0,  7'd41, 7'd57, 7'd0,  7'd11, 7'd73,
    7'd57, 7'd6,  7'd57, 7'd73, 7'd67, 7'd57, 7'd73, 7'd10,
    7'd57, 7'd73, 7'd6,  7'd57, 7'd73, 7'd57, 7'd73, 7'd73
  };

  // Which source operator lands on six-operator slot `target` (1..6)
  function automatic op_slot_t op_slot(input logic [2:0] alg, input logic [2:0] target);
    op_slot_t r;
    r.used = (target >= 3'd3);
    r.slot = 2'(target - 3'd3);
    if (alg == ALG_MAP_B) begin
      case (target)
        3'd3:    r.slot = 2'd2;
        3'd4:    r.slot = 2'd0;
        3'd5:    r.slot = 2'd1;
        default: r.slot = 2'd3;
      endcase
    end else if (alg == ALG_MAP_C) begin
      case (target)
        3'd3:    r.slot = 2'd0;
        3'd4:    r.slot = 2'd3;
        3'd5:    r.slot = 2'd1;
        default: r.slot = 2'd2;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fmvc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fmvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/fmvc_decode.sv @@
// Request decode: maps a converted index to one source byte address and a
// conversion kind, holds the entry-written flags and the algorithm/LFO copies.
// Depends on fmvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmvc_decode (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          req_type_i,
  input  wire logic [7:0]                    byte_index_i,
  input  wire logic [7:0]                    write_data_i,
  output logic                               ram_we_o,
  output logic      [fmvc_pkg::VOICE_AW-1:0] ram_waddr_o,
  output logic      [fmvc_pkg::VOICE_AW-1:0] ram_raddr_o,
  output fmvc_pkg::stage_t                   stage_o
);

  logic [fmvc_pkg::VOICE_DEPTH-1:0] present_q;
  logic [6:0]                       alg_byte_q;
  logic [6:0]                       lfo_byte_q;
  fmvc_pkg::stage_t                 stage_q, stage_d;

  logic                 is_read;
  logic [2:0]           alg;
  logic [2:0]           blk;
  logic [7:0]           fld_wide;
  logic [4:0]           fld;
  logic [2:0]           target;
  fmvc_pkg::op_slot_t   sel;
  logic [6:0]           base;
  logic [7:0]           wave_t;

  assign is_read     = accept_i && (req_type_i == fmvc_pkg::REQ_READ);
  assign ram_we_o    = accept_i && (req_type_i == fmvc_pkg::REQ_WRITE) && !byte_index_i[7];
  assign ram_waddr_o = byte_index_i[fmvc_pkg::VOICE_AW-1:0];
  assign alg         = alg_byte_q[2:0];

  always_comb begin
    blk = 3'd0;
    for (int n = 1; n < 6; n++) begin
      if (byte_index_i >= 8'(n * fmvc_pkg::OP_BYTES)) begin
        blk = 3'(n);
      end
    end
    fld_wide = byte_index_i - 8'({5'd0, blk} * fmvc_pkg::OP_BYTES);
    fld      = fld_wide[4:0];
    target   = 3'd6 - blk;
    wave_t   = byte_index_i - (fmvc_pkg::IDX_WAVE_FIRST - 8'd1);
    if (byte_index_i < fmvc_pkg::IDX_OP_END) begin
      sel = fmvc_pkg::op_slot(alg, target);
    end else begin
      sel = fmvc_pkg::op_slot(alg, wave_t[2:0]);
    end
    base = fmvc_pkg::OP_BASE[sel.slot];
  end

  always_comb begin
    stage_d.pend    = is_read;
    stage_d.kind    = fmvc_pkg::KIND_CONST;
    stage_d.cval    = 8'd0;
    ram_raddr_o     = '0;
    if (byte_index_i < fmvc_pkg::IDX_OP_END) begin
      if (!sel.used) begin
        // silent operator defaults
        if (fld == 5'd8) begin
          stage_d.cval = fmvc_pkg::BREAK_DEF;
        end else if (fld == 5'd18) begin
          stage_d.cval = fmvc_pkg::COARSE_DEF;
        end
      end else begin
        case (fld)
          5'd0: begin
            stage_d.kind = fmvc_pkg::KIND_SCALE20;
            ram_raddr_o  = base;
          end
          5'd1, 5'd2: begin
            stage_d.kind = fmvc_pkg::KIND_SCALE31;
            ram_raddr_o  = 7'(base + 7'(fld));
          end
          5'd3: begin
            stage_d.kind = fmvc_pkg::KIND_SCALE10;
            ram_raddr_o  = 7'(base + 7'd3);
          end
          5'd4: stage_d.cval = fmvc_pkg::CAP_LEVEL;
          5'd5: begin
            stage_d.kind = fmvc_pkg::KIND_SCALE15;
            ram_raddr_o  = 7'(base + 7'd4);
          end
          5'd8: stage_d.cval = fmvc_pkg::BREAK_DEF;
          5'd13: begin
            stage_d.kind = fmvc_pkg::KIND_AMS;
            ram_raddr_o  = 7'(base + 7'd9);
          end
          5'd14: begin
            stage_d.kind = fmvc_pkg::KIND_SENS;
            stage_d.cval = {6'd0, lfo_byte_q[3:2]};
            ram_raddr_o  = 7'(base + 7'd6);
          end
          5'd15: begin
            stage_d.kind = fmvc_pkg::KIND_LOW3;
            ram_raddr_o  = 7'(base + 7'd6);
          end
          5'd16: begin
            stage_d.kind = fmvc_pkg::KIND_CAP99;
            ram_raddr_o  = 7'(base + 7'd7);
          end
          5'd18: begin
            stage_d.kind = fmvc_pkg::KIND_COARSE;
            ram_raddr_o  = 7'(base + 7'd8);
          end
          5'd19: begin
            stage_d.kind = fmvc_pkg::KIND_FINE;
            ram_raddr_o  = 7'(base + 7'd8);
          end
          5'd20: begin
            stage_d.kind = fmvc_pkg::KIND_DETUNE;
            ram_raddr_o  = 7'(base + 7'd9);
          end
          default: stage_d.cval = 8'd0;
        endcase
      end
    end else begin
      case (byte_index_i) inside
        8'd126: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd67;
        end
        8'd127: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd68;
        end
        8'd128: stage_d.cval = fmvc_pkg::CAP_LEVEL;
        8'd129: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd69;
        end
        8'd130: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd70;
        end
        8'd131, 8'd132: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd71;
        end
        8'd133: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'd72;
        end
        8'd134: stage_d.cval = fmvc_pkg::ALG_CODE[alg];
        8'd135: stage_d.cval = {5'd0, alg_byte_q[5:3]};
        8'd136: stage_d.cval = 8'd1;
        [8'd137:8'd140]: begin
          stage_d.kind = fmvc_pkg::KIND_CAP99;
          ram_raddr_o  = 7'(byte_index_i - 8'd96);
        end
        8'd141: stage_d.cval = {7'd0, alg_byte_q[6]};
        8'd142: stage_d.cval = fmvc_pkg::LFO_WAVE[lfo_byte_q[1:0]];
        8'd143: stage_d.cval = {6'd0, lfo_byte_q[6:5]};
        8'd144: begin
          stage_d.kind = fmvc_pkg::KIND_CAP48;
          ram_raddr_o  = 7'd46;
        end
        [8'd145:8'd154]: begin
          stage_d.kind = fmvc_pkg::KIND_NAME;
          ram_raddr_o  = 7'(byte_index_i - 8'd88);
        end
        [fmvc_pkg::IDX_WAVE_FIRST:fmvc_pkg::IDX_WAVE_LAST]: begin
          if (sel.used) begin
            stage_d.kind = fmvc_pkg::KIND_WAVE;
            ram_raddr_o  = fmvc_pkg::WAVE_SRC[sel.slot];
          end
        end
        default: stage_d.cval = 8'd0;
      endcase
    end
    // look up the flag of the address chosen above
    stage_d.present = present_q[ram_raddr_o];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      alg_byte_q <= '0;
      lfo_byte_q <= '0;
      stage_q    <= '0;
    end else begin
      stage_q <= stage_d;
      if (ram_we_o) begin
        present_q[ram_waddr_o] <= 1'b1;
        // keep copies of the bytes that steer the decode
        if (ram_waddr_o == fmvc_pkg::ADDR_ALG) begin
          alg_byte_q <= write_data_i[6:0];
        end
        if (ram_waddr_o == fmvc_pkg::ADDR_LFO) begin
          lfo_byte_q <= write_data_i[6:0];
        end
      end
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ hdl/fmvc_convert.sv @@
// Convert stage: turns the fetched source byte into the converted voice byte
// and registers the result. Depends on fmvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmvc_convert (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fmvc_pkg::stage_t stage_i,
  input  wire logic [7:0]       rdata_i,
  output logic                  valid_o,
  output logic      [7:0]       data_o
);

  logic       valid_q;
  logic [7:0] data_q, data_d;
  logic [7:0] b;
  logic [4:0] div;
  logic [20:0] mul_k;
  logic [fmvc_pkg::SCALE_PW-1:0] prod;
  logic [7:0] scaled;

  // never-written entries read as zero
  assign b = stage_i.present ? rdata_i : 8'd0;

  always_comb begin
    case (stage_i.kind)
      fmvc_pkg::KIND_SCALE20: begin
        div   = 5'd20;
        mul_k = fmvc_pkg::SCALE_K20;
      end
      fmvc_pkg::KIND_SCALE10: begin
        div   = 5'd10;
        mul_k = fmvc_pkg::SCALE_K10;
      end
      fmvc_pkg::KIND_SCALE15: begin
        div   = 5'd15;
        mul_k = fmvc_pkg::SCALE_K15;
      end
      default: begin
        div   = 5'd31;
        mul_k = fmvc_pkg::SCALE_K31;
      end
    endcase
    prod = fmvc_pkg::SCALE_PW'(b[4:0]) * fmvc_pkg::SCALE_PW'(mul_k);
    // at or above the divisor the scaled value saturates
    if (b >= {3'd0, div}) begin
      scaled = fmvc_pkg::CAP_LEVEL;
    end else begin
      scaled = {1'b0, prod[fmvc_pkg::SCALE_SHIFT +: 7]};
    end
  end

  always_comb begin
    case (stage_i.kind)
      fmvc_pkg::KIND_CONST:   data_d = stage_i.cval;
      fmvc_pkg::KIND_SCALE20,
      fmvc_pkg::KIND_SCALE31,
      fmvc_pkg::KIND_SCALE10,
      fmvc_pkg::KIND_SCALE15: data_d = scaled;
      fmvc_pkg::KIND_CAP99:
        data_d = (b > fmvc_pkg::CAP_LEVEL) ? fmvc_pkg::CAP_LEVEL : b;
      fmvc_pkg::KIND_CAP48:
        data_d = (b > fmvc_pkg::CAP_TRANSPOSE) ? fmvc_pkg::CAP_TRANSPOSE : b;
      fmvc_pkg::KIND_AMS:     data_d = {6'd0, b[4:3]};
      fmvc_pkg::KIND_SENS:    data_d = b[6] ? stage_i.cval : 8'd0;
      fmvc_pkg::KIND_LOW3:    data_d = {5'd0, b[2:0]};
      fmvc_pkg::KIND_COARSE:  data_d = {3'd0, fmvc_pkg::RATIO_COARSE[b[5:0]]};
      fmvc_pkg::KIND_FINE:    data_d = {1'b0, fmvc_pkg::RATIO_FINE[b[5:0]]};
      fmvc_pkg::KIND_DETUNE:  data_d = {5'd0, b[2:0]} + 8'd4;
      fmvc_pkg::KIND_NAME:
        data_d = ({1'b0, b[6:0]} >= fmvc_pkg::NAME_BLANK) ? {1'b0, b[6:0]}
                                                          : fmvc_pkg::NAME_BLANK;
      fmvc_pkg::KIND_WAVE:    data_d = {5'd0, b[6:4]};
      default:                data_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.pend;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/fm_voice_format_converter_core.sv @@
// Top level of the FM voice format converter: decode, voice RAM and convert.
// Depends on fmvc_pkg, fmvc_ram, fmvc_decode and fmvc_convert.
// A read item shows read_valid_o for one cycle, after accept.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Between accept and the result lie the registered voice RAM read and the result register.
// Reset clears the written-entry flags, so every stored voice byte reads as zero.
`timescale 1ns / 1ps
`default_nettype none

module fm_voice_format_converter_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       req_type_i,
  input  wire logic [7:0] byte_index_i,
  input  wire logic [7:0] write_data_i,
  output logic            read_valid_o,
  output logic      [7:0] read_data_o
);

  logic                          accept;
  logic                          ram_we;
  logic [fmvc_pkg::VOICE_AW-1:0] ram_waddr;
  logic [fmvc_pkg::VOICE_AW-1:0] ram_raddr;
  logic [7:0]                    ram_rdata;
  fmvc_pkg::stage_t              stage;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  fmvc_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .byte_index_i (byte_index_i),
    .write_data_i (write_data_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_raddr_o  (ram_raddr),
    .stage_o      (stage)
  );

  fmvc_ram #(
    .Width (8),
    .Depth (fmvc_pkg::VOICE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (write_data_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fmvc_convert u_convert (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .rdata_i (ram_rdata),
    .valid_o (read_valid_o),
    .data_o  (read_data_o)
  );

  // A read item yields a result once through the RAM read and result registers.
  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == fmvc_pkg::REQ_READ) |-> ##2 read_valid_o)
    else $error("read item produced no result");

  // A write item yields no result.
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == fmvc_pkg::REQ_WRITE) |-> ##2 !read_valid_o)
    else $error("write item produced a result");

  // Reads past the waveform range return zero.
  a_out_of_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == fmvc_pkg::REQ_READ) &&
    (byte_index_i > fmvc_pkg::IDX_WAVE_LAST) |-> ##2 (read_data_o == 8'd0))
    else $error("out-of-range read returned nonzero data");

  // Waveform reads stay within three bits.
  a_wave_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == fmvc_pkg::REQ_READ) &&
    (byte_index_i >= fmvc_pkg::IDX_WAVE_FIRST) |-> ##2 (read_data_o[7:3] == 5'd0))
    else $error("waveform read out of range");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for fm_voice_format_converter_core: writes packed voice bytes,
// reads converted bytes and waveforms, and checks each read against a local predictor.
// Depends on fmvc_pkg for the request codes.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 4;

  localparam int OP_SRC_BASE [4] = '{30, 10, 20, 0};
  localparam int OP_WAVE_ADDR [4] = '{80, 76, 78, 74};
  localparam int ALG_ID [8] = '{1, 14, 8, 7, 5, 22, 31, 32};
  localparam int LFO_SHAPE [4] = '{2, 3, 0, 5};
  localparam int FREQ_COARSE [64] = '{
    0, 0, 0, 0, 1, 1, 1, 1,  2, 2, 3, 2, 2, 4, 4, 3,
    5, 3, 5, 6, 4, 4, 7, 7,  5, 8, 8, 5, 9, 6, 7, 10,
    6, 7, 11, 10, 12, 7, 8, 8,  13, 8, 14, 10, 9, 15, 14, 9,
    10, 16, 11, 10, 11, 12, 11, 18,  13, 12, 20, 14, 13, 15, 14, 15
  };
  localparam int FREQ_FINE [64] = '{
    0, 42, 56, 74, 0, 41, 57, 73,  0, 41, 0, 57, 73, 0, 6, 57,
    0, 73, 13, 0, 57, 73, 0, 1,  57, 0, 6, 73, 0, 57, 41, 0,
    73, 57, 0, 13, 0, 73, 57, 59,  0, 73, 0, 41, 57, 0, 11, 73,
    57, 6, 57, 73, 67, 57, 73, 10,  57, 73, 6, 57, 73, 57, 73, 73
  };

  typedef struct {
    logic       drain;
    int         idle_pct;
    logic       kind;
    logic [7:0] idx;
    logic [7:0] data;
  } voice_req_t;

  typedef struct {
    logic [7:0] idx;
    logic [7:0] data;
  } read_expect_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       req_type_i = fmvc_pkg::REQ_WRITE;
  logic [7:0] byte_index_i = 8'd0;
  logic [7:0] write_data_i = 8'd0;
  logic       read_valid_o;
  logic [7:0] read_data_o;

  voice_req_t   pending_q [$];
  read_expect_t read_expect_q [$];
  logic [7:0]   voice_mem [128];
  voice_req_t   cur;
  int           errors = 0;
  int           cycles = 0;
  int           n_writes = 0;
  int           n_reads = 0;
  int           n_far_reads = 0;
  int           n_ignored = 0;
  int           n_checked = 0;

  fm_voice_format_converter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .byte_index_i(byte_index_i),
    .write_data_i(write_data_i),
    .read_valid_o(read_valid_o),
    .read_data_o (read_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clamp_to(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic int op_target(input int alg, input int op);
    int t;
    t = op + 3;
    if (alg == 1) begin
      case (op)
        0: t = 4;
        1: t = 5;
        2: t = 3;
        default: t = 6;
      endcase
    end else if (alg == 2) begin
      case (op)
        0: t = 3;
        1: t = 5;
        2: t = 6;
        default: t = 4;
      endcase
    end
    return t;
  endfunction

  // Converted byte or waveform at a read index, from the current voice contents
  function automatic logic [7:0] convert_byte(input logic [7:0] idx);
    int conv [161];
    int alg, tgt, base, sb, f, i, c;
    for (i = 0; i < 161; i++) conv[i] = 0;
    alg = int'(voice_mem[40] & 8'h07);
    for (tgt = 1; tgt <= 6; tgt++) begin
      conv[(6 - tgt) * 21 + 8] = 39;
      conv[(6 - tgt) * 21 + 18] = 1;
    end
    for (i = 0; i < 4; i++) begin
      sb = OP_SRC_BASE[i];
      tgt = op_target(alg, i);
      base = (6 - tgt) * 21;
      f = int'(voice_mem[sb + 8] & 8'h3f);
      conv[base + 0] = clamp_to(int'(voice_mem[sb + 0]) * 99 / 20, 99);
      conv[base + 1] = clamp_to(int'(voice_mem[sb + 1]) * 99 / 31, 99);
      conv[base + 2] = clamp_to(int'(voice_mem[sb + 2]) * 99 / 31, 99);
      conv[base + 3] = clamp_to(int'(voice_mem[sb + 3]) * 99 / 10, 99);
      conv[base + 4] = 99;
      conv[base + 5] = clamp_to(int'(voice_mem[sb + 4]) * 99 / 15, 99);
      conv[base + 13] = int'((voice_mem[sb + 9] >> 3) & 8'h03);
      conv[base + 14] = voice_mem[sb + 6][6] ? int'((voice_mem[45] >> 2) & 8'h03) : 0;
      conv[base + 15] = int'(voice_mem[sb + 6] & 8'h07);
      conv[base + 16] = clamp_to(int'(voice_mem[sb + 7]), 99);
      conv[base + 18] = FREQ_COARSE[f];
      conv[base + 19] = FREQ_FINE[f];
      conv[base + 20] = int'(voice_mem[sb + 9] & 8'h07) + 4;
      conv[155 + tgt - 1] = int'((voice_mem[OP_WAVE_ADDR[i]] >> 4) & 8'h07);
    end
    conv[126] = clamp_to(int'(voice_mem[67]), 99);
    conv[127] = clamp_to(int'(voice_mem[68]), 99);
    conv[128] = 99;
    conv[129] = clamp_to(int'(voice_mem[69]), 99);
    conv[130] = clamp_to(int'(voice_mem[70]), 99);
    conv[131] = clamp_to(int'(voice_mem[71]), 99);
    conv[132] = clamp_to(int'(voice_mem[71]), 99);
    conv[133] = clamp_to(int'(voice_mem[72]), 99);
    conv[134] = ALG_ID[alg] - 1;
    conv[135] = int'((voice_mem[40] >> 3) & 8'h07);
    conv[136] = 1;
    conv[137] = clamp_to(int'(voice_mem[41]), 99);
    conv[138] = clamp_to(int'(voice_mem[42]), 99);
    conv[139] = clamp_to(int'(voice_mem[43]), 99);
    conv[140] = clamp_to(int'(voice_mem[44]), 99);
    conv[141] = int'(voice_mem[40][6]);
    conv[142] = LFO_SHAPE[voice_mem[45][1:0]];
    conv[143] = int'((voice_mem[45] >> 4) & 8'h07) / 2;
    conv[144] = clamp_to(int'(voice_mem[46]), 48);
    for (i = 0; i < 10; i++) begin
      c = int'(voice_mem[57 + i] & 8'h7f);
      conv[145 + i] = (c >= 32) ? c : 32;
    end
    return (idx <= 8'd160) ? 8'(conv[idx]) : 8'd0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_item(input logic kind, input int idx, input int data, input int pct);
    voice_req_t it;
    it.drain = 1'b0;
    it.idle_pct = pct;
    it.kind = kind;
    it.idx = 8'(idx);
    it.data = 8'(data);
    pending_q.push_back(it);
  endtask

  task automatic push_drain();
    voice_req_t it;
    it.drain = 1'b1;
    it.idle_pct = 0;
    it.kind = fmvc_pkg::REQ_WRITE;
    it.idx = 8'd0;
    it.data = 8'd0;
    pending_q.push_back(it);
  endtask

  // Driver: retire the accepted item into the predictor, then present the next one
  always @(posedge clk_i) begin
    read_expect_t e;
    logic taken;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        if (cur.kind == fmvc_pkg::REQ_WRITE) begin
          if (cur.idx < 8'd128) voice_mem[cur.idx[6:0]] = cur.data;
        end else begin
          e.idx = cur.idx;
          e.data = convert_byte(cur.idx);
          read_expect_q.push_back(e);
        end
      end
      if (!start || taken) begin
        if (pending_q.size() > 0 && pending_q[0].drain) begin
          // hold off until every read result is back
          start <= 1'b0;
          if (!taken && read_expect_q.size() == 0) void'(pending_q.pop_front());
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= pending_q[0].idle_pct) begin
          cur = pending_q.pop_front();
          start <= 1'b1;
          req_type_i <= cur.kind;
          byte_index_i <= cur.idx;
          write_data_i <= cur.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest pending read
  always @(posedge clk_i) begin
    read_expect_t e;
    if (rst_ni && read_valid_o !== 1'b0) begin
      if (read_expect_q.size() == 0) begin
        report_mismatch($sformatf("read result 0x%02h with no read pending", read_data_o));
      end else begin
        e = read_expect_q.pop_front();
        n_checked++;
        if (read_data_o !== e.data)
          report_mismatch($sformatf("index %0d: read_data 0x%02h, expected 0x%02h",
                                    e.idx, read_data_o, e.data));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n, r, pct, addr, data;
    for (int i = 0; i < 128; i++) voice_mem[i] = 8'd0;

    // directed: empty voice, out-of-range indices, field extremes
    push_item(fmvc_pkg::REQ_READ, 0, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 134, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 155, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 160, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 161, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 255, 8'hff, 0);
    push_item(fmvc_pkg::REQ_WRITE, 128, 8'hff, 0);
    push_item(fmvc_pkg::REQ_WRITE, 255, 8'hff, 0);
    push_item(fmvc_pkg::REQ_READ, 0, 0, 0);
    push_item(fmvc_pkg::REQ_WRITE, 40, 8'hff, 0);
    push_item(fmvc_pkg::REQ_READ, 134, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 135, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 141, 0, 0);
    push_item(fmvc_pkg::REQ_WRITE, 57, 8'h1f, 0);
    push_item(fmvc_pkg::REQ_WRITE, 58, 8'h7f, 0);
    push_item(fmvc_pkg::REQ_WRITE, 59, 8'h80, 0);
    push_item(fmvc_pkg::REQ_READ, 145, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 146, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 147, 0, 0);
    push_item(fmvc_pkg::REQ_WRITE, 46, 8'hff, 0);
    push_item(fmvc_pkg::REQ_READ, 144, 0, 0);
    push_item(fmvc_pkg::REQ_WRITE, 30, 8'hff, 0);
    push_item(fmvc_pkg::REQ_WRITE, 38, 8'h3f, 0);
    push_item(fmvc_pkg::REQ_READ, 63, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 81, 0, 0);
    push_item(fmvc_pkg::REQ_READ, 82, 0, 0);
    push_drain();

    // random: mostly in-range writes and reads, some ignored writes and far reads
    n = 0;
    while (n < 900) begin
      pct = (n < 300) ? 8 : (n < 600) ? 53 : 0;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        addr = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 40 : 45)
                                           : $urandom_range(0, 127);
        data = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        push_item(fmvc_pkg::REQ_WRITE, addr, data, pct);
        n_writes++;
        n++;
      end else if (r < 48) begin
        push_item(fmvc_pkg::REQ_WRITE, $urandom_range(128, 255), $urandom_range(0, 255), pct);
        n_ignored++;
      end else if (r < 92) begin
        push_item(fmvc_pkg::REQ_READ, $urandom_range(0, 160), $urandom_range(0, 255), pct);
        n_reads++;
        n++;
      end else begin
        push_item(fmvc_pkg::REQ_READ, $urandom_range(161, 255), $urandom_range(0, 255), pct);
        n_far_reads++;
        n++;
      end
      if (n == 300 || n == 600) push_drain();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start) @(posedge clk_i);
    while (read_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d random writes, %0d ignored writes, %0d reads in range, %0d beyond.",
             n_writes, n_ignored, n_reads, n_far_reads);
    $display("Checked %0d read results across three idle profiles, %0d mismatches.",
             n_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
